FILE: hdl/rmtq_pkg.sv
`timescale 1ns / 1ps

package rmtq_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 28;

  localparam int SUM_W      = DATA_WIDTH + 3;
  localparam int RAD_W      = 2 * ((SUM_W + FRAC_BITS) / 2);
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int MAG_W      = ROOT_W - 1;
  localparam int LANES      = 4;
  localparam int NEG_W      = 3;
  localparam int PIPE_DEPTH = ROOT_W + 2;
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;
  localparam int LANE_W = 3;

  localparam logic signed [SUM_W-1:0] ONE_FX = SUM_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [LANES-1:0][SUM_W-2:0] sum;
    logic [NEG_W-1:0]            neg;
  } root_in_t;

  typedef struct packed {
    logic [LANES-1:0][ROOT_W-1:0] root;
    logic [NEG_W-1:0]             neg;
  } root_out_t;

  function automatic logic [SUM_W-2:0] clamp_sum(logic signed [SUM_W-1:0] s);
    return s[SUM_W-1] ? '0 : s[SUM_W-2:0];
  endfunction

  function automatic logic [DATA_WIDTH-1:0] apply_sign(logic [MAG_W-1:0] mag, logic neg);
    logic [DATA_WIDTH-1:0] ext;
    ext = DATA_WIDTH'(mag);
    return neg ? (~ext + DATA_WIDTH'(1)) : ext;
  endfunction

endpackage

FILE: hdl/rmtq_root_pipe.sv
`timescale 1ns / 1ps

module rmtq_root_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rmtq_pkg::root_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rmtq_pkg::root_out_t out_data_o
);

  typedef logic [rmtq_pkg::LANES-1:0][rmtq_pkg::REM_W-1:0]  rem_vec_t;
  typedef logic [rmtq_pkg::LANES-1:0][rmtq_pkg::ROOT_W-1:0] root_vec_t;
  typedef logic [rmtq_pkg::LANES-1:0][rmtq_pkg::RAD_W-1:0]  rad_vec_t;

  logic                          vld_q    [rmtq_pkg::ROOT_W];
  logic                          adv      [rmtq_pkg::ROOT_W+1];
  logic                          src_vld  [rmtq_pkg::ROOT_W];
  rem_vec_t                      src_rem  [rmtq_pkg::ROOT_W];
  root_vec_t                     src_root [rmtq_pkg::ROOT_W];
  rad_vec_t                      src_rad  [rmtq_pkg::ROOT_W];
  logic [rmtq_pkg::NEG_W-1:0]    src_neg  [rmtq_pkg::ROOT_W];
  rem_vec_t                      rem_d    [rmtq_pkg::ROOT_W];
  root_vec_t                     root_d   [rmtq_pkg::ROOT_W];
  rad_vec_t                      rad_d    [rmtq_pkg::ROOT_W];
  rem_vec_t                      rem_q    [rmtq_pkg::ROOT_W];
  root_vec_t                     root_q   [rmtq_pkg::ROOT_W];
  rad_vec_t                      rad_q    [rmtq_pkg::ROOT_W];
  logic [rmtq_pkg::NEG_W-1:0]    neg_q    [rmtq_pkg::ROOT_W];

  assign adv[rmtq_pkg::ROOT_W] = out_ready_i;

  for (genvar k = 0; k < rmtq_pkg::ROOT_W; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src_vld[k]  = in_valid_i;
      assign src_rem[k]  = '0;
      assign src_root[k] = '0;
      assign src_neg[k]  = in_data_i.neg;
      for (genvar l = 0; l < rmtq_pkg::LANES; l++) begin : g_rad
        assign src_rad[k][l] = rmtq_pkg::RAD_W'({in_data_i.sum[l],
                                                 {rmtq_pkg::FRAC_BITS{1'b0}}});
      end
    end else begin : g_next
      assign src_vld[k]  = vld_q[k-1];
      assign src_rem[k]  = rem_q[k-1];
      assign src_root[k] = root_q[k-1];
      assign src_rad[k]  = rad_q[k-1];
      assign src_neg[k]  = neg_q[k-1];
    end

    for (genvar l = 0; l < rmtq_pkg::LANES; l++) begin : g_lane
      logic [rmtq_pkg::REM_W-1:0] rem_sh;
      logic [rmtq_pkg::REM_W-1:0] trial;
      logic                       fits;

      assign rem_sh = {src_rem[k][l][rmtq_pkg::REM_W-3:0],
                       src_rad[k][l][rmtq_pkg::RAD_W-1 -: 2]};
      assign trial  = {src_root[k][l], 2'b01};
      assign fits   = (rem_sh >= trial);
      assign rem_d[k][l]  = fits ? (rem_sh - trial) : rem_sh;
      assign root_d[k][l] = {src_root[k][l][rmtq_pkg::ROOT_W-2:0], fits};
      assign rad_d[k][l]  = src_rad[k][l] << 2;
    end

    assign adv[k] = !vld_q[k] || adv[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_q[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k] && src_vld[k]) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
        neg_q[k]  <= src_neg[k];
      end
    end
  end

  assign in_ready_o      = adv[0];
  assign out_valid_o     = vld_q[rmtq_pkg::ROOT_W-1];
  assign out_data_o.root = root_q[rmtq_pkg::ROOT_W-1];
  assign out_data_o.neg  = neg_q[rmtq_pkg::ROOT_W-1];

endmodule

FILE: hdl/rotation_matrix_to_quaternion_top.sv
`timescale 1ns / 1ps

// Converts a 3x3 rotation matrix in signed Q3.28 into quaternion x, y, z, w in Q3.28. Each
// magnitude is floor(sqrt(S) / 2) with S one plus a signed sum of the diagonal, clamped at
// zero; x, y and z take the sign of an off-diagonal difference. The block accepts one matrix
// per clock while in_stall_o is low, and each result passes through these registers in order:
// one stage forms the four diagonal sums, 31 stages resolve one root bit each in four parallel
// square-root lanes, and one output register applies the halving and signs.
// Stall on the output holds only the stages that are full, so empty stages keep filling.
module rotation_matrix_to_quaternion_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [rmtq_pkg::DATA_WIDTH-1:0] m00_i,
  input  logic signed [rmtq_pkg::DATA_WIDTH-1:0] m01_i,
  input  logic signed [rmtq_pkg::DATA_WIDTH-1:0] m02_i,
  input  logic signed [rmtq_pkg::DATA_WIDTH-1:0] m10_i,
  input  logic signed [rmtq_pkg::DATA_WIDTH-1:0] m11_i,
  input  logic signed [rmtq_pkg::DATA_WIDTH-1:0] m12_i,
  input  logic signed [rmtq_pkg::DATA_WIDTH-1:0] m20_i,
  input  logic signed [rmtq_pkg::DATA_WIDTH-1:0] m21_i,
  input  logic signed [rmtq_pkg::DATA_WIDTH-1:0] m22_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [rmtq_pkg::DATA_WIDTH-1:0] quat_x_o,
  output logic signed [rmtq_pkg::DATA_WIDTH-1:0] quat_y_o,
  output logic signed [rmtq_pkg::DATA_WIDTH-1:0] quat_z_o,
  output logic        [rmtq_pkg::DATA_WIDTH-2:0] quat_w_o
);

  logic signed [rmtq_pkg::SUM_W-1:0] e00;
  logic signed [rmtq_pkg::SUM_W-1:0] e11;
  logic signed [rmtq_pkg::SUM_W-1:0] e22;
  logic signed [rmtq_pkg::SUM_W-1:0] sum_x;
  logic signed [rmtq_pkg::SUM_W-1:0] sum_y;
  logic signed [rmtq_pkg::SUM_W-1:0] sum_z;
  logic signed [rmtq_pkg::SUM_W-1:0] sum_w;

  rmtq_pkg::root_in_t  s0_d;
  rmtq_pkg::root_in_t  s0_q;
  logic                s0_vld_q;
  logic                s0_adv;

  logic                pipe_in_ready;
  logic                pipe_out_valid;
  logic                pipe_out_ready;
  rmtq_pkg::root_out_t pipe_out;

  logic                                   out_vld_q;
  logic                                   out_adv;
  logic        [rmtq_pkg::DATA_WIDTH-1:0] quat_x_d;
  logic        [rmtq_pkg::DATA_WIDTH-1:0] quat_y_d;
  logic        [rmtq_pkg::DATA_WIDTH-1:0] quat_z_d;
  logic        [rmtq_pkg::DATA_WIDTH-2:0] quat_w_d;
  logic        [rmtq_pkg::DATA_WIDTH-1:0] quat_x_q;
  logic        [rmtq_pkg::DATA_WIDTH-1:0] quat_y_q;
  logic        [rmtq_pkg::DATA_WIDTH-1:0] quat_z_q;
  logic        [rmtq_pkg::DATA_WIDTH-2:0] quat_w_q;

  assign e00 = rmtq_pkg::SUM_W'(m00_i);
  assign e11 = rmtq_pkg::SUM_W'(m11_i);
  assign e22 = rmtq_pkg::SUM_W'(m22_i);

  assign sum_w = rmtq_pkg::ONE_FX + e00 + e11 + e22;
  assign sum_x = rmtq_pkg::ONE_FX + e00 - e11 - e22;
  assign sum_y = rmtq_pkg::ONE_FX - e00 + e11 - e22;
  assign sum_z = rmtq_pkg::ONE_FX - e00 - e11 + e22;

  always_comb begin
    s0_d.sum[rmtq_pkg::LANE_X] = rmtq_pkg::clamp_sum(sum_x);
    s0_d.sum[rmtq_pkg::LANE_Y] = rmtq_pkg::clamp_sum(sum_y);
    s0_d.sum[rmtq_pkg::LANE_Z] = rmtq_pkg::clamp_sum(sum_z);
    s0_d.sum[rmtq_pkg::LANE_W] = rmtq_pkg::clamp_sum(sum_w);
    s0_d.neg[rmtq_pkg::LANE_X] = (m21_i < m12_i);
    s0_d.neg[rmtq_pkg::LANE_Y] = (m02_i < m20_i);
    s0_d.neg[rmtq_pkg::LANE_Z] = (m10_i < m01_i);
  end

  assign s0_adv     = !s0_vld_q || pipe_in_ready;
  assign in_stall_o = !s0_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (s0_adv) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_adv && in_valid_i) begin
      s0_q <= s0_d;
    end
  end

  rmtq_root_pipe u_root_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_vld_q),
    .in_ready_o  (pipe_in_ready),
    .in_data_i   (s0_q),
    .out_valid_o (pipe_out_valid),
    .out_ready_i (pipe_out_ready),
    .out_data_o  (pipe_out)
  );

  assign out_adv        = !out_vld_q || !out_stall_i;
  assign pipe_out_ready = out_adv;

  assign quat_x_d = rmtq_pkg::apply_sign(
                      pipe_out.root[rmtq_pkg::LANE_X][rmtq_pkg::ROOT_W-1:1],
                      pipe_out.neg[rmtq_pkg::LANE_X]);
  assign quat_y_d = rmtq_pkg::apply_sign(
                      pipe_out.root[rmtq_pkg::LANE_Y][rmtq_pkg::ROOT_W-1:1],
                      pipe_out.neg[rmtq_pkg::LANE_Y]);
  assign quat_z_d = rmtq_pkg::apply_sign(
                      pipe_out.root[rmtq_pkg::LANE_Z][rmtq_pkg::ROOT_W-1:1],
                      pipe_out.neg[rmtq_pkg::LANE_Z]);
  assign quat_w_d = (rmtq_pkg::DATA_WIDTH-1)'(
                      pipe_out.root[rmtq_pkg::LANE_W][rmtq_pkg::ROOT_W-1:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= pipe_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && pipe_out_valid) begin
      quat_x_q <= quat_x_d;
      quat_y_q <= quat_y_d;
      quat_z_q <= quat_z_d;
      quat_w_q <= quat_w_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign quat_x_o    = quat_x_q;
  assign quat_y_o    = quat_y_q;
  assign quat_z_o    = quat_z_q;
  assign quat_w_o    = quat_w_q;

endmodule

FILE: hdl/rmtq_checker.sv
`timescale 1ns / 1ps

module rmtq_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [rmtq_pkg::DATA_WIDTH-1:0] quat_x_o,
  input logic signed [rmtq_pkg::DATA_WIDTH-1:0] quat_y_o,
  input logic signed [rmtq_pkg::DATA_WIDTH-1:0] quat_z_o,
  input logic        [rmtq_pkg::DATA_WIDTH-2:0] quat_w_o
);

  logic                       in_acc;
  logic                       out_acc;
  logic [rmtq_pkg::CNT_W-1:0] cnt_d;
  logic [rmtq_pkg::CNT_W-1:0] cnt_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + rmtq_pkg::CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - rmtq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output transaction was dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(quat_x_o) && $stable(quat_y_o) &&
                                   $stable(quat_z_o) && $stable(quat_w_o))
    else $error("Output payload changed while stalled.");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("Output transaction without a matching input transaction.");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rmtq_pkg::CNT_W'(rmtq_pkg::PIPE_DEPTH))
    else $error("More transactions in flight than the pipeline can hold.");

endmodule

bind rotation_matrix_to_quaternion_top rmtq_checker u_rmtq_checker (.*);
